>>> rtl/tfwrl_pkg.sv
package tfwrl_pkg;

    // Fixed field widths
    localparam int UID_W   = 10;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_USER_LIMIT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_USER_WINDOW   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GLOBAL_LIMIT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GLOBAL_WINDOW = 2'd3;

    // Configuration reset values
    localparam logic [CFG_W-1:0] USER_LIMIT_RST    = 16'd10;
    localparam logic [CFG_W-1:0] USER_WINDOW_RST   = 16'd1000;
    localparam logic [CFG_W-1:0] GLOBAL_LIMIT_RST  = 16'd100;
    localparam logic [CFG_W-1:0] GLOBAL_WINDOW_RST = 16'd1000;

    // Verdict codes
    typedef enum logic [1:0] {
        VERDICT_SERVED = 2'd0,
        VERDICT_GLOBAL = 2'd1,
        VERDICT_USER   = 2'd2
    } t_verdict;

    // Decision stage to control: table write request and verdict
    typedef struct packed {
        logic     wr_en;
        t_verdict verdict;
    } t_judge_ctl;

endpackage

>>> rtl/tfwrl_req_if.sv
interface tfwrl_req_if #(
    parameter int STAMP_BITS = 32
);
    logic                        valid;
    logic                        ready;
    logic [tfwrl_pkg::UID_W-1:0] user_id;
    logic [STAMP_BITS-1:0]       stamp;

    modport source (output valid, output user_id, output stamp, input ready);
    modport sink   (input valid, input user_id, input stamp, output ready);
endinterface

>>> rtl/tfwrl_rsp_if.sv
interface tfwrl_rsp_if;
    logic                        valid;
    logic                        ready;
    tfwrl_pkg::t_verdict         verdict;
    logic [tfwrl_pkg::UID_W-1:0] user_echo;

    modport source (output valid, output verdict, output user_echo, input ready);
    modport sink   (input valid, input verdict, input user_echo, output ready);
endinterface

>>> rtl/tfwrl_ram.sv
module tfwrl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port; read returns the old word on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

>>> rtl/tfwrl_front.sv
module tfwrl_front #(
    parameter int USERS      = 1024,
    parameter int STAMP_BITS = 32
) (
    input  logic                               i_clk,
    input  logic                               i_load,
    input  logic [tfwrl_pkg::UID_W-1:0]        i_uid,
    input  logic [STAMP_BITS-1:0]              i_stamp,
    input  logic [tfwrl_pkg::CFG_W-1:0]        i_user_window,
    input  logic [tfwrl_pkg::CFG_W-1:0]        i_global_window,
    output logic [tfwrl_pkg::UID_W-1:0]        o_uid,
    output logic [STAMP_BITS-1:0]              o_stamp,
    output logic [$clog2(USERS)-1:0]           o_idx,
    output logic [((STAMP_BITS > tfwrl_pkg::CFG_W) ? STAMP_BITS : tfwrl_pkg::CFG_W):0] o_uend,
    output logic [((STAMP_BITS > tfwrl_pkg::CFG_W) ? STAMP_BITS : tfwrl_pkg::CFG_W):0] o_gend
);
    localparam int UID_W = tfwrl_pkg::UID_W;
    localparam int CFG_W = tfwrl_pkg::CFG_W;
    localparam int IW    = $clog2(USERS);
    localparam int END_W = ((STAMP_BITS > CFG_W) ? STAMP_BITS : CFG_W) + 1;

    logic [UID_W-1:0]      r_uid;
    logic [STAMP_BITS-1:0] r_stamp;
    logic [CFG_W-1:0]      w_ulen_m1;
    logic [CFG_W-1:0]      w_glen_m1;

    // Request holding register
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_uid   <= i_uid;
            r_stamp <= i_stamp;
        end
    end

    // Table index: user id modulo USERS
    generate
        if (USERS >= (2 ** UID_W)) begin : g_idx_wide
            assign o_idx = IW'(r_uid);
        end else if ((USERS & (USERS - 1)) == 0) begin : g_idx_pow2
            assign o_idx = r_uid[IW-1:0];
        end else begin : g_idx_recip
            // Quotient by reciprocal at load, exact for every 10-bit id
            localparam int RSH  = 20;
            localparam int PW   = UID_W + RSH + 1;
            localparam logic [RSH:0] RECIP = (RSH + 1)'(((2 ** RSH) + USERS - 1) / USERS);
            localparam logic [UID_W-1:0] USERS_C = UID_W'(USERS);

            logic [PW-1:0]    w_prod;
            logic [UID_W-1:0] r_q;
            logic [UID_W-1:0] w_rem;

            assign w_prod = PW'(i_uid) * PW'(RECIP);

            always_ff @(posedge i_clk) begin
                if (i_load) begin
                    r_q <= w_prod[UID_W+RSH-1:RSH];
                end
            end

            assign w_rem = r_uid - UID_W'(r_q * USERS_C);
            assign o_idx = w_rem[IW-1:0];
        end
    endgenerate

    // Window ends: stamp + length - 1, a zero length counts as one
    assign w_ulen_m1 = (i_user_window == '0) ? '0 : i_user_window - CFG_W'(1);
    assign w_glen_m1 = (i_global_window == '0) ? '0 : i_global_window - CFG_W'(1);

    assign o_uend  = END_W'(r_stamp) + END_W'(w_ulen_m1);
    assign o_gend  = END_W'(r_stamp) + END_W'(w_glen_m1);
    assign o_uid   = r_uid;
    assign o_stamp = r_stamp;
endmodule

>>> rtl/tfwrl_judge.sv
module tfwrl_judge #(
    parameter int STAMP_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_fire,
    input  logic [STAMP_BITS-1:0]         i_stamp,
    input  logic [((STAMP_BITS > tfwrl_pkg::CFG_W) ? STAMP_BITS : tfwrl_pkg::CFG_W):0] i_uend,
    input  logic [((STAMP_BITS > tfwrl_pkg::CFG_W) ? STAMP_BITS : tfwrl_pkg::CFG_W):0] i_gend,
    input  logic [tfwrl_pkg::CFG_W-1:0]   i_user_limit,
    input  logic [tfwrl_pkg::CFG_W-1:0]   i_global_limit,
    input  logic [((STAMP_BITS > tfwrl_pkg::CFG_W) ? STAMP_BITS : tfwrl_pkg::CFG_W)
                  + tfwrl_pkg::CFG_W + 1:0] i_entry,
    output logic [((STAMP_BITS > tfwrl_pkg::CFG_W) ? STAMP_BITS : tfwrl_pkg::CFG_W)
                  + tfwrl_pkg::CFG_W + 1:0] o_entry,
    output tfwrl_pkg::t_judge_ctl         o_ctl
);
    localparam int CFG_W   = tfwrl_pkg::CFG_W;
    localparam int END_W   = ((STAMP_BITS > CFG_W) ? STAMP_BITS : CFG_W) + 1;
    localparam int ENTRY_W = 1 + CFG_W + END_W;

    // Global window state
    logic             r_g_started;
    logic [CFG_W-1:0] r_g_budget;
    logic [END_W-1:0] r_g_end;
    logic [CFG_W-1:0] n_g_budget;

    logic [END_W-1:0] w_stamp;
    logic             w_g_new;
    logic [CFG_W-1:0] w_gb;
    logic [END_W-1:0] w_gend;
    logic             w_e_valid;
    logic [CFG_W-1:0] w_e_bud;
    logic [END_W-1:0] w_e_end;
    logic             w_u_new;
    logic [CFG_W-1:0] w_ub;
    logic [END_W-1:0] w_uend;

    assign w_stamp = END_W'(i_stamp);

    // Global refill when no window yet or the stamp is past its end
    assign w_g_new = !r_g_started || (w_stamp > r_g_end);
    assign w_gb    = w_g_new ? i_global_limit : r_g_budget;
    assign w_gend  = w_g_new ? i_gend : r_g_end;

    // User entry: create or refill
    assign w_e_valid = i_entry[ENTRY_W-1];
    assign w_e_bud   = i_entry[ENTRY_W-2 -: CFG_W];
    assign w_e_end   = i_entry[END_W-1:0];
    assign w_u_new   = !w_e_valid || (w_stamp > w_e_end);
    assign w_ub      = w_u_new ? i_user_limit : w_e_bud;
    assign w_uend    = w_u_new ? i_uend : w_e_end;

    // Verdict and writeback
    always_comb begin
        o_ctl.wr_en   = 1'b0;
        o_ctl.verdict = tfwrl_pkg::VERDICT_GLOBAL;
        o_entry       = {1'b1, w_ub, w_uend};
        n_g_budget    = w_gb;
        if (w_gb == '0) begin
            o_ctl.verdict = tfwrl_pkg::VERDICT_GLOBAL;
        end else if (w_ub == '0) begin
            o_ctl.wr_en   = 1'b1;
            o_ctl.verdict = tfwrl_pkg::VERDICT_USER;
        end else begin
            o_ctl.wr_en   = 1'b1;
            o_ctl.verdict = tfwrl_pkg::VERDICT_SERVED;
            o_entry       = {1'b1, w_ub - CFG_W'(1), w_uend};
            n_g_budget    = w_gb - CFG_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_started <= 1'b0;
            r_g_budget  <= '0;
            r_g_end     <= '0;
        end else if (i_fire) begin
            r_g_started <= 1'b1;
            r_g_budget  <= n_g_budget;
            r_g_end     <= w_gend;
        end
    end
endmodule

>>> rtl/two_level_fixed_window_rate_limiter.sv
// Two-level fixed-window rate limiter. Each request transfer (user_id,
// stamp) yields exactly one verdict transfer: served, dropped by the global
// limit, or dropped by the user's limit, with user_echo returning the id.
// Requests are taken one per clock cycle sustained unless verdicts are held
// back or the clearing pass runs; a verdict follows the index stage, table
// read and decision into the output register. While it waits there, two
// more requests can move in behind it before the input stalls. The rate is
// set by the per-user table, a single-port-write RAM that is read as a
// request enters the decision stage and written back as it leaves, with a
// bypass for back-to-back requests of the same user. After reset the block
// runs a clearing pass over the table, during which no request is taken;
// configuration writes are taken at any time but belong in idle periods.
// User ids at or above USERS fold onto the table modulo USERS.
module two_level_fixed_window_rate_limiter #(
    parameter int USERS      = 1024,
    parameter int STAMP_BITS = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    tfwrl_req_if.sink                           i_req,
    tfwrl_rsp_if.source                         o_rsp,
    input  logic                                i_cfg_we,
    input  logic [tfwrl_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [tfwrl_pkg::CFG_W-1:0]         i_cfg_data
);
    localparam int UID_W   = tfwrl_pkg::UID_W;
    localparam int CFG_W   = tfwrl_pkg::CFG_W;
    localparam int IW      = $clog2(USERS);
    localparam int END_W   = ((STAMP_BITS > CFG_W) ? STAMP_BITS : CFG_W) + 1;
    localparam int ENTRY_W = 1 + CFG_W + END_W;

    // Configuration registers
    logic [CFG_W-1:0] r_user_limit;
    logic [CFG_W-1:0] r_user_window;
    logic [CFG_W-1:0] r_global_limit;
    logic [CFG_W-1:0] r_global_window;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_user_limit    <= tfwrl_pkg::USER_LIMIT_RST;
            r_user_window   <= tfwrl_pkg::USER_WINDOW_RST;
            r_global_limit  <= tfwrl_pkg::GLOBAL_LIMIT_RST;
            r_global_window <= tfwrl_pkg::GLOBAL_WINDOW_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                tfwrl_pkg::CFG_USER_LIMIT:    r_user_limit    <= i_cfg_data;
                tfwrl_pkg::CFG_USER_WINDOW:   r_user_window   <= i_cfg_data;
                tfwrl_pkg::CFG_GLOBAL_LIMIT:  r_global_limit  <= i_cfg_data;
                tfwrl_pkg::CFG_GLOBAL_WINDOW: r_global_window <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Pipeline control
    logic r_s1_v;
    logic r_s2_v;
    logic r_out_v;
    logic r_clr_busy;
    logic [IW-1:0] r_clr_idx;
    logic w_in_xfer;
    logic w_s1_adv;
    logic w_s2_fire;

    assign w_s2_fire   = r_s2_v && (!r_out_v || o_rsp.ready);
    assign w_s1_adv    = r_s1_v && (!r_s2_v || w_s2_fire);
    assign i_req.ready = !r_clr_busy && (!r_s1_v || w_s1_adv);
    assign w_in_xfer   = i_req.valid && i_req.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (w_in_xfer) begin
                r_s1_v <= 1'b1;
            end else if (w_s1_adv) begin
                r_s1_v <= 1'b0;
            end
            if (w_s1_adv) begin
                r_s2_v <= 1'b1;
            end else if (w_s2_fire) begin
                r_s2_v <= 1'b0;
            end
            if (w_s2_fire) begin
                r_out_v <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // Clearing pass over the user table after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clr_busy) begin
            r_clr_idx <= r_clr_idx + IW'(1);
            if (r_clr_idx == IW'(USERS - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // Index stage
    logic [UID_W-1:0]      w_s1_uid;
    logic [STAMP_BITS-1:0] w_s1_stamp;
    logic [IW-1:0]         w_s1_idx;
    logic [END_W-1:0]      w_s1_uend;
    logic [END_W-1:0]      w_s1_gend;

    tfwrl_front #(
        .USERS      (USERS),
        .STAMP_BITS (STAMP_BITS)
    ) u_front (
        .i_clk           (i_clk),
        .i_load          (w_in_xfer),
        .i_uid           (i_req.user_id),
        .i_stamp         (i_req.stamp),
        .i_user_window   (r_user_window),
        .i_global_window (r_global_window),
        .o_uid           (w_s1_uid),
        .o_stamp         (w_s1_stamp),
        .o_idx           (w_s1_idx),
        .o_uend          (w_s1_uend),
        .o_gend          (w_s1_gend)
    );

    // Decision stage registers
    logic [UID_W-1:0]      r_s2_uid;
    logic [STAMP_BITS-1:0] r_s2_stamp;
    logic [IW-1:0]         r_s2_idx;
    logic [END_W-1:0]      r_s2_uend;
    logic [END_W-1:0]      r_s2_gend;

    always_ff @(posedge i_clk) begin
        if (w_s1_adv) begin
            r_s2_uid   <= w_s1_uid;
            r_s2_stamp <= w_s1_stamp;
            r_s2_idx   <= w_s1_idx;
            r_s2_uend  <= w_s1_uend;
            r_s2_gend  <= w_s1_gend;
        end
    end

    // User table
    logic                  w_wr_en;
    logic [IW-1:0]         w_wr_addr;
    logic [ENTRY_W-1:0]    w_wr_data;
    logic [ENTRY_W-1:0]    w_rd_data;
    logic [ENTRY_W-1:0]    w_new_entry;
    logic [ENTRY_W-1:0]    w_cur_entry;
    tfwrl_pkg::t_judge_ctl w_ctl;

    assign w_wr_en   = r_clr_busy || (w_s2_fire && w_ctl.wr_en);
    assign w_wr_addr = r_clr_busy ? r_clr_idx : r_s2_idx;
    assign w_wr_data = r_clr_busy ? '0 : w_new_entry;

    tfwrl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (USERS)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_s1_adv),
        .i_rd_addr (w_s1_idx),
        .o_rd_data (w_rd_data)
    );

    // Bypass: a write to the entry being read in the same cycle
    logic               r_byp_hit;
    logic [ENTRY_W-1:0] r_byp_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp_hit <= 1'b0;
        end else if (w_s1_adv) begin
            r_byp_hit <= w_s2_fire && w_ctl.wr_en && (r_s2_idx == w_s1_idx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv) begin
            r_byp_entry <= w_new_entry;
        end
    end

    assign w_cur_entry = r_byp_hit ? r_byp_entry : w_rd_data;

    tfwrl_judge #(
        .STAMP_BITS (STAMP_BITS)
    ) u_judge (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (w_s2_fire),
        .i_stamp        (r_s2_stamp),
        .i_uend         (r_s2_uend),
        .i_gend         (r_s2_gend),
        .i_user_limit   (r_user_limit),
        .i_global_limit (r_global_limit),
        .i_entry        (w_cur_entry),
        .o_entry        (w_new_entry),
        .o_ctl          (w_ctl)
    );

    // Output register
    tfwrl_pkg::t_verdict r_out_verdict;
    logic [UID_W-1:0]    r_out_uid;

    always_ff @(posedge i_clk) begin
        if (w_s2_fire) begin
            r_out_verdict <= w_ctl.verdict;
            r_out_uid     <= r_s2_uid;
        end
    end

    assign o_rsp.valid     = r_out_v;
    assign o_rsp.verdict   = r_out_verdict;
    assign o_rsp.user_echo = r_out_uid;
endmodule

>>> verif/tfwrl_checker.sv
module tfwrl_checker #(
    parameter int USERS      = 1024,
    parameter int STAMP_BITS = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_req_valid,
    input  logic                              i_req_ready,
    input  logic [tfwrl_pkg::UID_W-1:0]       i_req_user_id,
    input  logic [STAMP_BITS-1:0]             i_req_stamp,
    input  logic                              i_rsp_valid,
    input  logic                              i_rsp_ready,
    input  tfwrl_pkg::t_verdict               i_rsp_verdict,
    input  logic [tfwrl_pkg::UID_W-1:0]       i_rsp_user_echo,
    input  logic                              i_cfg_we,
    input  logic [tfwrl_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [tfwrl_pkg::CFG_W-1:0]       i_cfg_data,
    output int                                o_errors,
    output int                                o_pending
);
    localparam int UID_W = tfwrl_pkg::UID_W;
    localparam int CFG_W = tfwrl_pkg::CFG_W;
    localparam int END_W = ((STAMP_BITS > CFG_W) ? STAMP_BITS : CFG_W) + 1;

    typedef struct packed {
        tfwrl_pkg::t_verdict verdict;
        logic [UID_W-1:0]    user_echo;
    } t_answer;

    // Verdicts owed by the block, oldest first
    t_answer expected_verdicts[$];
    int      fail_total = 0;

    // Shadow copy of the limiter's registers and tables
    logic [CFG_W-1:0] user_limit;
    logic [CFG_W-1:0] user_window;
    logic [CFG_W-1:0] global_limit;
    logic [CFG_W-1:0] global_window;
    logic             user_seen   [USERS];
    logic [CFG_W-1:0] user_budget [USERS];
    logic [END_W-1:0] user_end    [USERS];
    logic [CFG_W-1:0] server_budget;
    logic [END_W-1:0] server_end;
    logic             server_open;

    assign o_errors = fail_total;

    // Last stamp of a window opened at stamp; zero length acts as one
    function automatic logic [END_W-1:0] window_close(input logic [STAMP_BITS-1:0] stamp,
                                                      input logic [CFG_W-1:0] len);
        logic [END_W-1:0] span;
        span = (len == '0) ? END_W'(1) : END_W'(len);
        return END_W'(stamp) + span - END_W'(1);
    endfunction

    // Decide one request and update the shadow tables
    function automatic tfwrl_pkg::t_verdict judge_request(input logic [UID_W-1:0] uid,
                                                          input logic [STAMP_BITS-1:0] stamp);
        int               slot;
        logic [END_W-1:0] wide;
        slot = int'(uid) % USERS;
        wide = END_W'(stamp);
        // global window opens on the first request past the old one
        if (!server_open || wide > server_end) begin
            server_open   = 1'b1;
            server_budget = global_limit;
            server_end    = window_close(stamp, global_window);
        end
        // global drop leaves the user entry alone
        if (server_budget == '0) begin
            return tfwrl_pkg::VERDICT_GLOBAL;
        end
        if (!user_seen[slot]) begin
            user_seen[slot]   = 1'b1;
            user_budget[slot] = user_limit;
            user_end[slot]    = window_close(stamp, user_window);
        end
        if (wide > user_end[slot]) begin
            user_budget[slot] = user_limit;
            user_end[slot]    = window_close(stamp, user_window);
        end
        if (user_budget[slot] == '0) begin
            return tfwrl_pkg::VERDICT_USER;
        end
        user_budget[slot] = user_budget[slot] - CFG_W'(1);
        server_budget     = server_budget - CFG_W'(1);
        return tfwrl_pkg::VERDICT_SERVED;
    endfunction

    always @(posedge i_clk) begin
        t_answer got;
        t_answer want;
        if (!i_rst_n) begin
            user_limit    = tfwrl_pkg::USER_LIMIT_RST;
            user_window   = tfwrl_pkg::USER_WINDOW_RST;
            global_limit  = tfwrl_pkg::GLOBAL_LIMIT_RST;
            global_window = tfwrl_pkg::GLOBAL_WINDOW_RST;
            foreach (user_seen[i]) user_seen[i] = 1'b0;
            server_budget = '0;
            server_end    = '0;
            server_open   = 1'b0;
            expected_verdicts.delete();
            o_pending <= 0;
        end else begin
            // verdict transfer: compare against the oldest expectation
            if (i_rsp_valid && i_rsp_ready) begin
                got.verdict   = i_rsp_verdict;
                got.user_echo = i_rsp_user_echo;
                if (expected_verdicts.size() == 0) begin
                    $error("unexpected verdict transfer: verdict %0d user_echo %0d",
                           got.verdict, got.user_echo);
                    fail_total++;
                end else begin
                    want = expected_verdicts.pop_front();
                    if (got.verdict !== want.verdict) begin
                        $error("verdict: expected %0d, got %0d", want.verdict, got.verdict);
                        fail_total++;
                    end
                    if (got.user_echo !== want.user_echo) begin
                        $error("user_echo: expected %0d, got %0d",
                               want.user_echo, got.user_echo);
                        fail_total++;
                    end
                end
            end
            // register writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    tfwrl_pkg::CFG_USER_LIMIT:    user_limit    = i_cfg_data;
                    tfwrl_pkg::CFG_USER_WINDOW:   user_window   = i_cfg_data;
                    tfwrl_pkg::CFG_GLOBAL_LIMIT:  global_limit  = i_cfg_data;
                    tfwrl_pkg::CFG_GLOBAL_WINDOW: global_window = i_cfg_data;
                    default: ;
                endcase
            end
            // request transfer: predict its verdict
            if (i_req_valid && i_req_ready) begin
                want.verdict   = judge_request(i_req_user_id, i_req_stamp);
                want.user_echo = i_req_user_id;
                expected_verdicts.push_back(want);
            end
            o_pending <= expected_verdicts.size();
        end
    end

endmodule

>>> verif/tb_top.sv
module tb_top;
    localparam int UID_W       = tfwrl_pkg::UID_W;
    localparam int CFG_W       = tfwrl_pkg::CFG_W;
    localparam int CFG_IDX_W   = tfwrl_pkg::CFG_IDX_W;
    localparam int USERS       = 1024;
    localparam int STAMP_BITS  = 32;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASES      = 7;
    localparam int PHASE_ITEMS = 145;
    localparam int HOT_USERS   = 6;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_data;
    int                   errors;
    int                   pending;
    int                   cycles = 0;
    bit                   idle_gaps = 1'b1;
    bit                   hold_wanted = 1'b0;
    bit                   hold_done = 1'b0;

    tfwrl_req_if #(.STAMP_BITS(STAMP_BITS)) req_ch ();
    tfwrl_rsp_if                            rsp_ch ();

    two_level_fixed_window_rate_limiter #(
        .USERS      (USERS),
        .STAMP_BITS (STAMP_BITS)
    ) i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    tfwrl_checker #(
        .USERS      (USERS),
        .STAMP_BITS (STAMP_BITS)
    ) u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_req_valid     (req_ch.valid),
        .i_req_ready     (req_ch.ready),
        .i_req_user_id   (req_ch.user_id),
        .i_req_stamp     (req_ch.stamp),
        .i_rsp_valid     (rsp_ch.valid),
        .i_rsp_ready     (rsp_ch.ready),
        .i_rsp_verdict   (rsp_ch.verdict),
        .i_rsp_user_echo (rsp_ch.user_echo),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data),
        .o_errors        (errors),
        .o_pending       (pending)
    );

    always #5 clk = ~clk;

    // Watchdog
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // One request transfer, after an optional gap
    task automatic offer(input logic [UID_W-1:0] uid, input logic [STAMP_BITS-1:0] stamp);
        int gap;
        gap = idle_gaps ? int'($urandom_range(0, 10)) : 0;
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.user_id <= uid;
        req_ch.stamp   <= stamp;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
    endtask

    // Stop offering and wait until every verdict has come back
    task automatic drain();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge clk);
    endtask

    // Reprogram all four registers while the block is idle
    task automatic set_limits(input logic [CFG_W-1:0] ul, input logic [CFG_W-1:0] uw,
                              input logic [CFG_W-1:0] gl, input logic [CFG_W-1:0] gw);
        drain();
        write_reg(tfwrl_pkg::CFG_USER_LIMIT, ul);
        write_reg(tfwrl_pkg::CFG_USER_WINDOW, uw);
        write_reg(tfwrl_pkg::CFG_GLOBAL_LIMIT, gl);
        write_reg(tfwrl_pkg::CFG_GLOBAL_WINDOW, gw);
        cfg_we <= 1'b0;
    endtask

    // Verdict sink: random stalls, one long hold-off on request
    initial begin : verdict_sink
        int stall;
        rsp_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (hold_wanted && !hold_done) begin
                hold_done = 1'b1;
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            stall = idle_gaps ? int'($urandom_range(0, 10)) : 0;
            if (stall > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge clk);
            while (!rsp_ch.valid) @(posedge clk);
        end
    end

    initial begin : stimulus
        logic [UID_W-1:0]      hot [HOT_USERS];
        logic [UID_W-1:0]      uid;
        logic [STAMP_BITS-1:0] now_stamp;
        logic [STAMP_BITS-1:0] stamp;
        logic [CFG_W-1:0]      ul, uw, gl, gw;
        int                    stride;
        int                    back;

        rst_n          <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_idx        <= tfwrl_pkg::CFG_USER_LIMIT;
        cfg_data       <= '0;
        req_ch.valid   <= 1'b0;
        req_ch.user_id <= '0;
        req_ch.stamp   <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset limits, then limit changes that keep held budgets
        offer(10'd0, 32'd0);
        offer(10'd1023, 32'd5);
        set_limits(16'd2, 16'd10, 16'd5, 16'd100);
        offer(10'd0, 32'd10);
        offer(10'd5, 32'd20);
        offer(10'd5, 32'd21);
        offer(10'd5, 32'd22);      // user budget empty
        offer(10'd5, 32'd15);      // older stamp, still in window
        offer(10'd5, 32'd30);      // past window end, refill
        offer(10'd7, 32'd2000);    // new global window
        offer(10'd8, 32'd2001);
        offer(10'd9, 32'd2002);
        offer(10'd10, 32'd2003);
        offer(10'd11, 32'd2004);
        offer(10'd12, 32'd2005);   // global budget empty, no entry made
        offer(10'd12, 32'd1500);
        // zero-length windows behave as length one
        set_limits(16'd1, 16'd0, 16'd3, 16'd0);
        offer(10'd12, 32'd3000);
        offer(10'd12, 32'd3000);
        offer(10'd12, 32'd3001);
        // zero limits
        set_limits(16'd0, 16'd10, 16'd0, 16'd10);
        offer(10'd20, 32'd4000);
        set_limits(16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        offer(10'd21, 32'd5000);
        offer(10'd0, 32'd5001);

        // Random phases, stamps climbing from phase to phase
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin
                    ul = 16'd10;   uw = 16'd1000; gl = 16'd100;  gw = 16'd1000;
                    stride = 10;
                end
                1: begin
                    ul = 16'hFFFF; uw = 16'hFFFF; gl = 16'hFFFF; gw = 16'hFFFF;
                    stride = 2000;
                end
                2: begin
                    ul = 16'd3;    uw = 16'd50;   gl = 16'd20;   gw = 16'd200;
                    stride = 6;
                end
                3: begin
                    ul = 16'd0;    uw = 16'd100;  gl = 16'd50;   gw = 16'd100;
                    stride = 3;
                end
                4: begin
                    ul = 16'd5;    uw = 16'd1;    gl = 16'd8;    gw = 16'd1;
                    stride = 1;
                end
                5: begin
                    ul = 16'd4;    uw = 16'd0;    gl = 16'd0;    gw = 16'd0;
                    stride = 2;
                end
                default: begin
                    ul = CFG_W'($urandom_range(0, 20));
                    uw = CFG_W'($urandom_range(0, 200));
                    gl = CFG_W'($urandom_range(0, 60));
                    gw = CFG_W'($urandom_range(0, 400));
                    stride = int'($urandom_range(1, 20));
                end
            endcase
            set_limits(ul, uw, gl, gw);
            idle_gaps = (p % 2 == 0);
            if (p == 2) hold_wanted = 1'b1;
            foreach (hot[i]) hot[i] = UID_W'($urandom_range(0, USERS - 1));
            now_stamp = (STAMP_BITS'(p + 1) << 29) | STAMP_BITS'($urandom & 32'h0FFF_FFFF);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                uid = ($urandom_range(0, 9) < 7) ? hot[$urandom_range(0, HOT_USERS - 1)]
                                                 : UID_W'($urandom_range(0, USERS - 1));
                now_stamp = now_stamp + STAMP_BITS'($urandom_range(0, stride));
                stamp     = now_stamp;
                // occasional late arrival
                if ($urandom_range(0, 9) == 0) begin
                    back  = int'($urandom_range(0, 4 * stride));
                    stamp = now_stamp - STAMP_BITS'(back);
                end
                offer(uid, stamp);
            end
        end

        // Top of the stamp range: window ends beyond 32 bits
        idle_gaps = 1'b1;
        set_limits(16'd1, 16'hFFFF, 16'd2, 16'hFFFF);
        offer(10'd1023, 32'hFFFF_FFFF);
        offer(10'd1023, 32'd0);
        offer(10'd1, 32'hFFFF_FFFF);
        offer(10'd2, 32'd1);

        drain();
        repeat (8) @(posedge clk);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
